// ===== hw/rtl/zip_local_header_parser_top_defines.svh =====
// assertion macros for the zip local header parser
`ifndef ZIP_LOCAL_HEADER_PARSER_TOP_DEFINES_SVH
`define ZIP_LOCAL_HEADER_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define ZLHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
// next-cycle implication, checked out of reset
`define ZLHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define ZLHP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ZLHP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/zlhp_pkg.sv =====
// types and constants shared by the zip local header parser modules
package zlhp_pkg;

	// parse phases
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_NAME   = 3'd1;
	localparam logic [2:0] PH_EXTRA  = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_DSIG   = 3'd4;
	localparam logic [2:0] PH_DCRC   = 3'd5;
	localparam logic [2:0] PH_DCOMP  = 3'd6;
	localparam logic [2:0] PH_DUNC   = 3'd7;

	localparam logic [31:0] DESC_SIGNATURE = 32'h0807_4b50;

	// general purpose flag bits
	localparam int FLAG_ENCRYPTED  = 0;
	localparam int FLAG_DESCRIPTOR = 3;
	localparam int FLAG_STRONG     = 6;

	// last byte index of the fixed header
	localparam logic [31:0] HDR_LAST = 32'd29;

	localparam int TDATA_W = 152;

	typedef struct packed {
		logic [31:0] crc;
		logic [31:0] length;
		logic [15:0] method;
		logic [15:0] version;
		logic [15:0] mod_time;
		logic [31:0] data_start;
		logic        encrypted;
		logic        enc_strong;
		logic        has_desc;
	} entry_info_t;

endpackage

// ===== hw/rtl/zlhp_parser.sv =====
// byte-wise parse state of the local file entries
module zlhp_parser #(
	parameter int POSITION_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            stream_byte,
	output logic                  done,
	output logic                  hdr_len_nz,
	output zlhp_pkg::entry_info_t info
);

	logic [2:0]  phase_q, n_phase;
	logic [31:0] cnt_q, n_cnt;
	logic [POSITION_BITS-1:0] pos_q, next_pos, start_q, n_start;
	logic [15:0] flag_q, n_flag, method_q, n_method, version_q, n_version, time_q, n_time;
	logic [31:0] hcrc_q, n_hcrc, comp_q, n_comp, hunc_q, n_hunc;
	logic [15:0] name_q, n_name, extra_q, n_extra;
	logic [31:0] dcrc_q, n_dcrc, dunc_q, n_dunc;
	logic [32:0] cnt1;
	logic        from_hdr, from_name, from_extra, from_data, desc_done;
	logic        pass_name, pass_extra, pass_data;
	logic [POSITION_BITS+31:0] start_ext;

	assign cnt1     = {1'b0, cnt_q} + 33'd1;
	assign next_pos = pos_q + POSITION_BITS'(1);

	always_comb begin
		n_phase   = phase_q;
		n_cnt     = cnt_q;
		n_start   = start_q;
		n_flag    = flag_q;
		n_method  = method_q;
		n_version = version_q;
		n_time    = time_q;
		n_hcrc    = hcrc_q;
		n_comp    = comp_q;
		n_hunc    = hunc_q;
		n_name    = name_q;
		n_extra   = extra_q;
		n_dcrc    = dcrc_q;
		n_dunc    = dunc_q;
		from_hdr   = 1'b0;
		from_name  = 1'b0;
		from_extra = 1'b0;
		from_data  = 1'b0;
		desc_done  = 1'b0;
		pass_name  = 1'b0;
		pass_extra = 1'b0;
		pass_data  = 1'b0;
		done       = 1'b0;

		unique case (phase_q)
			zlhp_pkg::PH_HEADER: begin
				if (cnt_q == 32'd0) begin
					n_flag    = '0;
					n_method  = '0;
					n_version = '0;
					n_time    = '0;
					n_hcrc    = '0;
					n_comp    = '0;
					n_hunc    = '0;
					n_name    = '0;
					n_extra   = '0;
					n_dcrc    = '0;
					n_dunc    = '0;
				end
				unique case (cnt_q[4:0])
					5'd4:  n_version[7:0]  = stream_byte;
					5'd5:  n_version[15:8] = stream_byte;
					5'd6:  n_flag[7:0]     = stream_byte;
					5'd7:  n_flag[15:8]    = stream_byte;
					5'd8:  n_method[7:0]   = stream_byte;
					5'd9:  n_method[15:8]  = stream_byte;
					5'd10: n_time[7:0]     = stream_byte;
					5'd11: n_time[15:8]    = stream_byte;
					5'd14: n_hcrc[7:0]     = stream_byte;
					5'd15: n_hcrc[15:8]    = stream_byte;
					5'd16: n_hcrc[23:16]   = stream_byte;
					5'd17: n_hcrc[31:24]   = stream_byte;
					5'd18: n_comp[7:0]     = stream_byte;
					5'd19: n_comp[15:8]    = stream_byte;
					5'd20: n_comp[23:16]   = stream_byte;
					5'd21: n_comp[31:24]   = stream_byte;
					5'd22: n_hunc[7:0]     = stream_byte;
					5'd23: n_hunc[15:8]    = stream_byte;
					5'd24: n_hunc[23:16]   = stream_byte;
					5'd25: n_hunc[31:24]   = stream_byte;
					5'd26: n_name[7:0]     = stream_byte;
					5'd27: n_name[15:8]    = stream_byte;
					5'd28: n_extra[7:0]    = stream_byte;
					5'd29: n_extra[15:8]   = stream_byte;
					default: ;
				endcase
				if (cnt_q >= zlhp_pkg::HDR_LAST) from_hdr = 1'b1;
				else n_cnt = cnt1[31:0];
			end
			zlhp_pkg::PH_NAME: begin
				if (cnt1 >= {17'd0, name_q}) from_name = 1'b1;
				else n_cnt = cnt1[31:0];
			end
			zlhp_pkg::PH_EXTRA: begin
				if (cnt1 >= {17'd0, extra_q}) from_extra = 1'b1;
				else n_cnt = cnt1[31:0];
			end
			zlhp_pkg::PH_DATA: begin
				if (cnt1 >= {1'b0, comp_q}) from_data = 1'b1;
				else n_cnt = cnt1[31:0];
			end
			zlhp_pkg::PH_DSIG, zlhp_pkg::PH_DCRC: begin
				unique case (cnt_q[1:0])
					2'd0: n_dcrc[7:0]   = stream_byte;
					2'd1: n_dcrc[15:8]  = stream_byte;
					2'd2: n_dcrc[23:16] = stream_byte;
					2'd3: n_dcrc[31:24] = stream_byte;
				endcase
				if (cnt_q >= 32'd3) begin
					n_cnt = '0;
					// a missing signature means these four bytes were the crc
					if (phase_q == zlhp_pkg::PH_DSIG && n_dcrc == zlhp_pkg::DESC_SIGNATURE) begin
						n_dcrc  = '0;
						n_phase = zlhp_pkg::PH_DCRC;
					end else begin
						n_phase = zlhp_pkg::PH_DCOMP;
					end
				end else begin
					n_cnt = cnt1[31:0];
				end
			end
			zlhp_pkg::PH_DCOMP: begin
				if (cnt_q >= 32'd3) begin
					n_cnt   = '0;
					n_phase = zlhp_pkg::PH_DUNC;
				end else begin
					n_cnt = cnt1[31:0];
				end
			end
			zlhp_pkg::PH_DUNC: begin
				unique case (cnt_q[1:0])
					2'd0: n_dunc[7:0]   = stream_byte;
					2'd1: n_dunc[15:8]  = stream_byte;
					2'd2: n_dunc[23:16] = stream_byte;
					2'd3: n_dunc[31:24] = stream_byte;
				endcase
				if (cnt_q >= 32'd3) desc_done = 1'b1;
				else n_cnt = cnt1[31:0];
			end
		endcase

		// skip over empty sections in the same byte
		if (from_hdr || from_name || from_extra || from_data) n_cnt = '0;
		if (from_hdr && n_name != 16'd0) n_phase = zlhp_pkg::PH_NAME;
		else pass_name = from_hdr || from_name;
		if (pass_name && n_extra != 16'd0) n_phase = zlhp_pkg::PH_EXTRA;
		else pass_extra = pass_name || from_extra;
		if (pass_extra) n_start = next_pos;
		if (pass_extra && n_comp != 32'd0) n_phase = zlhp_pkg::PH_DATA;
		else pass_data = pass_extra || from_data;
		if (pass_data && n_flag[zlhp_pkg::FLAG_DESCRIPTOR]) n_phase = zlhp_pkg::PH_DSIG;
		else done = pass_data || desc_done;

		if (done) begin
			n_phase = zlhp_pkg::PH_HEADER;
			n_cnt   = '0;
		end
	end

	assign start_ext = {32'd0, n_start};

	always_comb begin
		info.crc        = (n_hcrc != 32'd0) ? n_hcrc : n_dcrc;
		info.length     = (n_hunc != 32'd0) ? n_hunc : n_dunc;
		info.method     = n_method;
		info.version    = n_version;
		info.mod_time   = n_time;
		info.data_start = start_ext[31:0];
		info.encrypted  = n_flag[zlhp_pkg::FLAG_ENCRYPTED];
		info.enc_strong = n_flag[zlhp_pkg::FLAG_ENCRYPTED] & n_flag[zlhp_pkg::FLAG_STRONG];
		info.has_desc   = n_flag[zlhp_pkg::FLAG_DESCRIPTOR];
	end

	assign hdr_len_nz = (n_hunc != 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= zlhp_pkg::PH_HEADER;
			cnt_q     <= '0;
			pos_q     <= '0;
			start_q   <= '0;
			flag_q    <= '0;
			method_q  <= '0;
			version_q <= '0;
			time_q    <= '0;
			hcrc_q    <= '0;
			comp_q    <= '0;
			hunc_q    <= '0;
			name_q    <= '0;
			extra_q   <= '0;
			dcrc_q    <= '0;
			dunc_q    <= '0;
		end else if (step) begin
			phase_q   <= n_phase;
			cnt_q     <= n_cnt;
			pos_q     <= next_pos;
			start_q   <= n_start;
			flag_q    <= n_flag;
			method_q  <= n_method;
			version_q <= n_version;
			time_q    <= n_time;
			hcrc_q    <= n_hcrc;
			comp_q    <= n_comp;
			hunc_q    <= n_hunc;
			name_q    <= n_name;
			extra_q   <= n_extra;
			dcrc_q    <= n_dcrc;
			dunc_q    <= n_dunc;
		end
	end

endmodule

// ===== hw/rtl/zlhp_select.sv =====
// best entry tracking by method, then size
module zlhp_select (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        multi_entry_mode,
	input  logic        fire,
	input  logic        hdr_len_nz,
	input  logic [31:0] length,
	input  logic [15:0] method,
	output logic        take
);

	logic [31:0] best_len_q;
	logic [15:0] best_method_q;
	logic        len_le;

	assign len_le = (length <= best_len_q);

	always_comb begin
		if (!multi_entry_mode) take = 1'b1;
		else if (!hdr_len_nz) take = 1'b0;
		else if (len_le) take = (method <= best_method_q);
		else take = (method < best_method_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_len_q    <= '1;
			best_method_q <= '1;
		end else if (fire && take) begin
			best_len_q    <= length;
			best_method_q <= method;
		end
	end

endmodule

// ===== hw/rtl/zip_local_header_parser_top.sv =====
// zip local file entry parser, one archive byte per item
// result: an entry is loaded into the result register as its last byte is parsed
// throughput: one byte per cycle while the result slot is free; the single parse
// pass between the input register and the result register decides each byte
// reset: arst_n clears parse phase, counters and offset; best entry to all ones
`include "zip_local_header_parser_top_defines.svh"

module zip_local_header_parser_top #(
	parameter int POSITION_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: multi_entry_mode
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	// archive bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] stream_byte
	// entry results
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] entry_crc, [63:32] entry_length, [79:64] entry_method,
	// [95:80] entry_version, [111:96] entry_mod_time, [143:112] data_start,
	// [144] encrypted, [145] enc_strong, [146] has_descriptor,
	// [147] taken, [151:148] zero
	output logic [zlhp_pkg::TDATA_W-1:0] m_tdata
);

	logic        mode_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_free;
	logic        proc;
	logic        done;
	logic        hdr_len_nz;
	logic        take;
	logic        out_valid_q;
	logic [zlhp_pkg::TDATA_W-1:0] out_data_q;
	zlhp_pkg::entry_info_t info;

	// the byte in the input register is parsed once the result slot can take it
	assign out_free = !out_valid_q || m_tready;
	assign proc     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || proc;

	// mode register, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_wen) begin
			mode_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	zlhp_parser #(
		.POSITION_BITS (POSITION_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (proc),
		.stream_byte (byte_s1),
		.done        (done),
		.hdr_len_nz  (hdr_len_nz),
		.info        (info)
	);

	zlhp_select u_select (
		.clk              (clk),
		.arst_n           (arst_n),
		.multi_entry_mode (mode_q),
		.fire             (proc && done),
		.hdr_len_nz       (hdr_len_nz),
		.length           (info.length),
		.method           (info.method),
		.take             (take)
	);

	// result register, only bytes that close an entry load it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= proc && done;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && done) begin
			out_data_q <= {4'd0, take, info.has_desc, info.enc_strong, info.encrypted,
				info.data_start, info.mod_time, info.version, info.method,
				info.length, info.crc};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// a waiting byte stays put until it is parsed
	`ZLHP_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !proc, valid_s1 && $stable(byte_s1))
	// strong encryption only comes with the encrypted flag
	`ZLHP_ASSERT_IMP(a_strong_enc, clk, arst_n, m_tvalid, !m_tdata[145] || m_tdata[144])
	// a taken result with nothing parsing behind it leaves the slot empty
	`ZLHP_ASSERT_NEXT(a_out_drain, clk, arst_n, m_tvalid && m_tready && !valid_s1, !m_tvalid)

endmodule
